// ===== rtl/lsfd_pkg.sv =====
`default_nettype none

package lsfd_pkg;

   localparam int STRIPS          = 8;
   localparam int SLOTS_PER_STRIP = 64;

   localparam int BYTE_W   = 8;
   localparam int KIND_W   = 2;
   localparam int STRIP_W  = 3;
   localparam int SLOT_W   = 6;
   localparam int WORD_W   = 16;
   localparam int PROD_W   = 24;

   localparam int STRIP_CNT_W = (STRIPS > 1) ? $clog2(STRIPS) : 1;
   localparam int SLOT_CNT_W  = (SLOTS_PER_STRIP > 1) ? $clog2(SLOTS_PER_STRIP) : 1;

   localparam logic [STRIP_CNT_W-1:0] LAST_STRIP = STRIP_CNT_W'(STRIPS - 1);
   localparam logic [SLOT_CNT_W-1:0]  LAST_SLOT  = SLOT_CNT_W'(SLOTS_PER_STRIP - 1);

   localparam logic [WORD_W-1:0] WORD_DATA_MAX = 16'hff00;
   localparam logic [WORD_W-1:0] WORD_SYNC     = 16'hffff;
   localparam logic [BYTE_W-1:0] BYTE_ZERO     = 8'h00;
   localparam logic [BYTE_W-1:0] BYTE_MARK     = 8'hf0;
   localparam logic [BYTE_W-1:0] BYTE_FILL     = 8'hff;

   typedef enum logic [KIND_W-1:0] {
      KIND_SYMBOL = 2'd0,
      KIND_GOOD   = 2'd1,
      KIND_BAD    = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      SYNC_GOOD        = 4'd0,
      SYNC_GOOD_00     = 4'd1,
      SYNC_GOOD_01_FE  = 4'd2,
      SYNC_GOOD_FF     = 4'd3,
      SYNC_GOOD_FFFF   = 4'd4,
      SYNC_GOOD_FFFFFF = 4'd5,
      SYNC_BAD         = 4'd6,
      SYNC_BAD_FF      = 4'd7,
      SYNC_BAD_FFFF    = 4'd8,
      SYNC_BAD_FFFFFF  = 4'd9
   } sync_state_type;

   typedef enum logic [2:0] {
      CLS_ZERO = 3'd0,
      CLS_LOW  = 3'd1,
      CLS_F0   = 3'd2,
      CLS_HIGH = 3'd3,
      CLS_FF   = 3'd4
   } byte_class_type;

   typedef struct packed {
      sync_state_type next;
      logic           say_good;
      logic           say_bad;
   } sync_step_type;

   typedef struct packed {
      logic                 valid;
      kind_type             kind;
      logic [STRIP_W-1:0]   strip;
      logic [SLOT_W-1:0]    slot;
      logic [BYTE_W-1:0]    line_byte_first;
      logic [BYTE_W-1:0]    line_byte_second;
   } result_type;

   function automatic byte_class_type classify(input logic [BYTE_W-1:0] b);
      byte_class_type c;
      if (b == BYTE_ZERO) c = CLS_ZERO;
      else if (b < BYTE_MARK) c = CLS_LOW;
      else if (b == BYTE_MARK) c = CLS_F0;
      else if (b == BYTE_FILL) c = CLS_FF;
      else c = CLS_HIGH;
      return c;
   endfunction

   function automatic sync_step_type sync_next(input sync_state_type s,
                                               input byte_class_type c);
      sync_step_type r;
      logic          is_ff;
      is_ff      = (c == CLS_FF);
      r.say_good = 1'b0;
      r.say_bad  = 1'b0;
      unique case (s)
         SYNC_GOOD: begin
            if (c == CLS_ZERO) r.next = SYNC_GOOD_00;
            else if (is_ff) r.next = SYNC_GOOD_FF;
            else r.next = SYNC_GOOD_01_FE;
         end
         SYNC_GOOD_00:     r.next = SYNC_GOOD;
         SYNC_GOOD_01_FE:  r.next = is_ff ? SYNC_BAD_FF : SYNC_GOOD;
         SYNC_GOOD_FF:     r.next = is_ff ? SYNC_GOOD_FFFF : SYNC_GOOD;
         SYNC_GOOD_FFFF:   r.next = is_ff ? SYNC_GOOD_FFFFFF : SYNC_BAD;
         SYNC_GOOD_FFFFFF: begin
            r.next     = is_ff ? SYNC_BAD_FFFFFF : SYNC_BAD;
            r.say_good = (c == CLS_F0);
         end
         SYNC_BAD_FF:      r.next = is_ff ? SYNC_BAD_FFFF : SYNC_BAD;
         SYNC_BAD_FFFF:    r.next = is_ff ? SYNC_BAD_FFFFFF : SYNC_BAD;
         SYNC_BAD_FFFFFF: begin
            r.next    = is_ff ? SYNC_BAD_FFFFFF : SYNC_BAD;
            r.say_bad = (c == CLS_F0);
         end
         // Unused codes behave like the plain bad state.
         default:          r.next = is_ff ? SYNC_BAD_FF : SYNC_BAD;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/lsfd_if.sv =====
`default_nettype none

interface lsfd_req_if;
   logic                          valid;
   logic                          ready;
   logic [lsfd_pkg::BYTE_W-1:0]   rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lsfd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lsfd_pkg::KIND_W-1:0]   kind;
   logic [lsfd_pkg::STRIP_W-1:0]  strip;
   logic [lsfd_pkg::SLOT_W-1:0]   slot;
   logic [lsfd_pkg::BYTE_W-1:0]   line_byte_first;
   logic [lsfd_pkg::BYTE_W-1:0]   line_byte_second;

   modport source (output valid, output kind, output strip, output slot,
                   output line_byte_first, output line_byte_second, input ready);
   modport sink   (input valid, input kind, input strip, input slot,
                   input line_byte_first, input line_byte_second, output ready);
endinterface

`default_nettype wire

// ===== rtl/lsfd_core.sv =====
`default_nettype none

module lsfd_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        step,
   input  wire logic [lsfd_pkg::BYTE_W-1:0] rx_byte,
   output      lsfd_pkg::result_type        result
);

   logic                                   in_sync_ff, in_sync_in;
   logic                                   have_low_ff, have_low_in;
   logic [lsfd_pkg::BYTE_W-1:0]            held_low_ff, held_low_in;
   logic [lsfd_pkg::STRIP_CNT_W-1:0]       strip_cnt_ff, strip_cnt_in;
   logic [lsfd_pkg::SLOT_CNT_W-1:0]        slot_cnt_ff, slot_cnt_in;
   lsfd_pkg::sync_state_type               sync_ff, sync_in;

   logic [lsfd_pkg::WORD_W-1:0]            word;
   logic [lsfd_pkg::PROD_W-1:0]            prod;
   lsfd_pkg::sync_step_type                sync_step;

   assign word      = {rx_byte, held_low_ff};
   // word * 0x101 is the word plus itself shifted up by one byte.
   assign prod      = {word, 8'h00} + lsfd_pkg::PROD_W'(word);
   assign sync_step = lsfd_pkg::sync_next(sync_ff, lsfd_pkg::classify(rx_byte));

   always_comb begin
      in_sync_in   = in_sync_ff;
      have_low_in  = have_low_ff;
      held_low_in  = held_low_ff;
      strip_cnt_in = strip_cnt_ff;
      slot_cnt_in  = slot_cnt_ff;
      sync_in      = sync_ff;

      result.valid            = 1'b0;
      result.kind             = lsfd_pkg::KIND_SYMBOL;
      result.strip            = '0;
      result.slot             = '0;
      result.line_byte_first  = '0;
      result.line_byte_second = '0;

      if (in_sync_ff) begin
         if (sync_step.say_good || sync_step.say_bad) begin
            result.valid = 1'b1;
            result.kind  = sync_step.say_good ? lsfd_pkg::KIND_GOOD : lsfd_pkg::KIND_BAD;
            in_sync_in   = 1'b0;
            have_low_in  = 1'b0;
            strip_cnt_in = '0;
            slot_cnt_in  = '0;
            sync_in      = lsfd_pkg::SYNC_GOOD;
         end else begin
            sync_in = sync_step.next;
         end
      end else if (!have_low_ff) begin
         held_low_in = rx_byte;
         have_low_in = 1'b1;
      end else begin
         have_low_in = 1'b0;
         if (word > lsfd_pkg::WORD_DATA_MAX) begin
            in_sync_in = 1'b1;
            sync_in    = (word == lsfd_pkg::WORD_SYNC) ? lsfd_pkg::SYNC_GOOD_FFFF
                                                       : lsfd_pkg::SYNC_BAD_FF;
         end else begin
            result.valid            = 1'b1;
            result.strip            = lsfd_pkg::STRIP_W'(strip_cnt_ff);
            result.slot             = lsfd_pkg::SLOT_W'(slot_cnt_ff);
            result.line_byte_first  = prod[15:8];
            result.line_byte_second = prod[23:16];
            if (slot_cnt_ff == lsfd_pkg::LAST_SLOT) begin
               slot_cnt_in = '0;
               if (strip_cnt_ff == lsfd_pkg::LAST_STRIP) begin
                  strip_cnt_in = '0;
                  in_sync_in   = 1'b1;
                  sync_in      = lsfd_pkg::SYNC_GOOD;
               end else begin
                  strip_cnt_in = strip_cnt_ff + 1'b1;
               end
            end else begin
               slot_cnt_in = slot_cnt_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_sync_ff   <= 1'b0;
         have_low_ff  <= 1'b0;
         strip_cnt_ff <= '0;
         slot_cnt_ff  <= '0;
         sync_ff      <= lsfd_pkg::SYNC_GOOD;
      end else if (step) begin
         in_sync_ff   <= in_sync_in;
         have_low_ff  <= have_low_in;
         strip_cnt_ff <= strip_cnt_in;
         slot_cnt_ff  <= slot_cnt_in;
         sync_ff      <= sync_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         held_low_ff <= held_low_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/led_strip_frame_deframer_top.sv =====
`default_nettype none
// Flow: an accepted byte moves from the input register through the core; its result, if any,
// is held in the result register for rsp. Throughput: one byte per cycle unless a result waits
// for rsp.ready; each register holds one transaction, so an empty input register can still
// take a byte. Reset (synchronous, active high) empties both registers and returns the
// deframer to the start of the data phase with all counters at zero.

module led_strip_frame_deframer_top (
   input wire logic    clock,
   input wire logic    reset,
   lsfd_req_if.sink    req,
   lsfd_rsp_if.source  rsp
);

   logic                            in_valid_ff;
   logic [lsfd_pkg::BYTE_W-1:0]     in_byte_ff;
   logic                            out_valid_ff;
   lsfd_pkg::result_type            out_ff;
   lsfd_pkg::result_type            result;
   logic                            advance;
   logic                            step;

   // The pipeline moves whenever the result register is free or being emptied.
   assign advance   = !out_valid_ff || rsp.ready;
   assign step      = advance && in_valid_ff;
   assign req.ready = !in_valid_ff || advance;

   lsfd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req.ready) begin
            in_valid_ff <= req.valid;
         end
         if (advance) begin
            out_valid_ff <= step && result.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         in_byte_ff <= req.rx_byte;
      end
      if (step && result.valid) begin
         out_ff <= result;
      end
   end

   assign rsp.valid            = out_valid_ff;
   assign rsp.kind             = out_ff.kind;
   assign rsp.strip            = out_ff.strip;
   assign rsp.slot             = out_ff.slot;
   assign rsp.line_byte_first  = out_ff.line_byte_first;
   assign rsp.line_byte_second = out_ff.line_byte_second;

endmodule

`default_nettype wire
